[design/eprm_pkg.sv]
// ----------------------------------------------------------------------------
// eprm_pkg
// Shared types and constants of the echo pulse range meter.
// ----------------------------------------------------------------------------
`default_nettype none

package eprm_pkg;

	localparam int TICK_W   = 16;
	localparam int RANGE_W  = 10;
	localparam int DIST_W   = 11;
	localparam int STAT_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RISE_TIMEOUT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ECHO     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE    = 3'd5;

	// Status codes of a result
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_RESP   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_TOO_CLOSE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_TOO_FAR   = 2'd3;

	// Input command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// floor(t*17/1000) == (t * DIST_RECIP) >> DIST_SHIFT for any 16-bit t
	localparam int              DIST_SHIFT = 26;
	localparam int              RECIP_W    = 21;
	localparam logic [RECIP_W-1:0] DIST_RECIP = 21'd1140851;
	localparam int              PROD_W     = TICK_W + RECIP_W;

	typedef struct packed {
		logic [TICK_W-1:0]  rise_timeout;
		logic [TICK_W-1:0]  high_timeout;
		logic [TICK_W-1:0]  min_echo;
		logic [TICK_W-1:0]  max_echo;
		logic [RANGE_W-1:0] min_cm;
		logic [RANGE_W-1:0] max_cm;
	} eprm_cfg_t;

endpackage

`default_nettype wire

[design/eprm_cfg.sv]
// ----------------------------------------------------------------------------
// eprm_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module eprm_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [eprm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [eprm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output eprm_pkg::eprm_cfg_t                    cfg
);
	import eprm_pkg::*;

	eprm_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_timeout <= 16'd1000;
			cfg_q.high_timeout <= 16'd25000;
			cfg_q.min_echo     <= 16'd117;
			cfg_q.max_echo     <= 16'd23529;
			cfg_q.min_cm       <= 10'd2;
			cfg_q.max_cm       <= 10'd400;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RISE_TIMEOUT: cfg_q.rise_timeout <= cfg_data;
				REG_HIGH_TIMEOUT: cfg_q.high_timeout <= cfg_data;
				REG_MIN_ECHO:     cfg_q.min_echo     <= cfg_data;
				REG_MAX_ECHO:     cfg_q.max_echo     <= cfg_data;
				REG_MIN_RANGE:    cfg_q.min_cm       <= cfg_data[RANGE_W-1:0];
				REG_MAX_RANGE:    cfg_q.max_cm       <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/eprm_meter.sv]
// ----------------------------------------------------------------------------
// eprm_meter
// Echo timing state machine: input register, phase/tick update, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module eprm_meter (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire eprm_pkg::eprm_cfg_t              cfg,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             cmd,
	input  wire logic                             echo_level,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [eprm_pkg::DIST_W-1:0]           distance_cm,
	output logic [eprm_pkg::STAT_W-1:0]           status
);
	import eprm_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_HIGH
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [TICK_W-1:0]   ticks_q, ticks_d, ticks_inc;
	logic                valid_s1, cmd_s1, echo_s1;
	logic                out_valid_q;
	logic [DIST_W-1:0]   dist_q, res_dist, ok_dist, far_dist, close_dist;
	logic [STAT_W-1:0]   stat_q, res_stat;
	logic                res_vld, adv, in_take;
	logic [PROD_W-1:0]   prod;

	// saturating tick count
	assign ticks_inc = (ticks_q == {TICK_W{1'b1}}) ? ticks_q : ticks_q + 1'b1;

	assign prod       = PROD_W'(ticks_q) * PROD_W'(DIST_RECIP);
	assign ok_dist    = prod[DIST_SHIFT +: DIST_W];
	assign far_dist   = DIST_W'(cfg.max_cm) + 1'b1;
	assign close_dist = (cfg.min_cm == '0) ? '0 : DIST_W'(cfg.min_cm) - 1'b1;

	always_comb begin
		phase_d  = phase_q;
		ticks_d  = ticks_q;
		res_vld  = 1'b0;
		res_dist = '0;
		res_stat = STAT_OK;
		if (cmd_s1 == CMD_START) begin
			ticks_d = '0;
			phase_d = PH_WAIT;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (echo_s1) begin
						ticks_d = '0;
						phase_d = PH_HIGH;
					end else begin
						ticks_d = ticks_inc;
						if (ticks_inc >= cfg.rise_timeout) begin
							res_vld  = 1'b1;
							res_stat = STAT_NO_RESP;
							phase_d  = PH_IDLE;
						end
					end
				end
				PH_HIGH: begin
					if (echo_s1) begin
						ticks_d = ticks_inc;
						if (ticks_inc > cfg.high_timeout) begin
							res_vld  = 1'b1;
							res_dist = far_dist;
							res_stat = STAT_TOO_FAR;
							phase_d  = PH_IDLE;
						end
					end else begin
						// falling edge: classify pulse length
						res_vld = 1'b1;
						phase_d = PH_IDLE;
						if (ticks_q < cfg.min_echo) begin
							res_dist = close_dist;
							res_stat = STAT_TOO_CLOSE;
						end else if (ticks_q <= cfg.max_echo) begin
							res_dist = ok_dist;
							res_stat = STAT_OK;
						end else begin
							res_dist = far_dist;
							res_stat = STAT_TOO_FAR;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// a request in s1 moves on unless it makes a result and the output is held
	assign adv      = valid_s1 && (!res_vld || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			ticks_q     <= '0;
			valid_s1    <= 1'b0;
			cmd_s1      <= CMD_TICK;
			echo_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			dist_q      <= '0;
			stat_q      <= STAT_OK;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
				cmd_s1   <= cmd;
				echo_s1  <= echo_level;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				phase_q <= phase_d;
				ticks_q <= ticks_d;
			end
			if (adv && res_vld) begin
				out_valid_q <= 1'b1;
				dist_q      <= res_dist;
				stat_q      <= res_stat;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign distance_cm = dist_q;
	assign status      = stat_q;

endmodule

`default_nettype wire

[design/echo_pulse_range_meter_core.sv]
// ----------------------------------------------------------------------------
// echo_pulse_range_meter_core
// Times an ultrasonic echo pulse in microsecond ticks and reports range.
// ----------------------------------------------------------------------------
// One request per clock is accepted unless a result is held at a stalled
// output. Each request (a start command or a tick with an echo sample) is
// held in an input register, where the phase and tick counter are updated
// and any result is formed; the result is then registered in an output
// register, from which it leaves once the output is not stalled. The loop
// through the phase/tick-counter update sets the rate of one request per
// cycle. Distance for a good pulse is floor(ticks*17/1000) cm, formed by a
// single constant multiply. Configuration writes are always ready and should
// be made while no measurement is in flight.
`default_nettype none

module echo_pulse_range_meter_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [eprm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [eprm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             cmd,
	input  wire logic                             echo_level,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [eprm_pkg::DIST_W-1:0]           distance_cm,
	output logic [eprm_pkg::STAT_W-1:0]           status
);
	import eprm_pkg::*;

	eprm_cfg_t cfg;

	eprm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	eprm_meter u_meter (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.echo_level  (echo_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.distance_cm (distance_cm),
		.status      (status)
	);

endmodule

`default_nettype wire
